### hdl/mspid_pkg.sv
package mspid_pkg;

  // control constants
  localparam int WARMUP_TICKS = 200;
  localparam int EARLY_END    = 290;
  localparam int STALL_LIMIT  = 50;
  localparam int STILL_MAX    = 63;
  localparam int SUM_LIMIT    = 3000;
  localparam int BRAKE_DRIVE  = -300;
  localparam int THR_FAST     = 35;
  localparam int THR_SLOW     = 43;

  // accumulator saturation before the divide, well outside any 16-bit drive
  localparam int SAT_MAX = 524287;
  localparam int SAT_MIN = -524288;

  // exact divide by ten for magnitudes below 2^20: floor(x * RECIP_10 / 2^RECIP_SHIFT)
  localparam int RECIP_10    = 1677722;
  localparam int RECIP_SHIFT = 24;

  localparam logic [1:0] SLOPE_UP1 = 2'd1;
  localparam logic [1:0] SLOPE_UP2 = 2'd2;

  localparam logic [2:0] ROAD_STRAIGHT   = 3'd1;
  localparam logic [2:0] ROAD_SMALL_S    = 3'd2;
  localparam logic [2:0] ROAD_T_JUNCTION = 3'd3;
  localparam logic [2:0] ROAD_U_TURN     = 3'd4;

  typedef enum logic [1:0] {
    MODE_RACE   = 2'd0,
    MODE_FAST   = 2'd1,
    MODE_STEADY = 2'd2,
    MODE_SAFE   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_DRIVE_MODE = 2'd0,
    REG_DRIVE_MAX  = 2'd1,
    REG_DRIVE_MIN  = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    RSN_PID     = 2'd0,
    RSN_BRAKE   = 2'd1,
    RSN_STOPPED = 2'd2,
    RSN_STALL   = 2'd3
  } reason_t;

  typedef struct packed {
    logic [15:0]       encoder_count;
    logic              moving_forward;
    logic              start_line_seen;
    logic [1:0]        slope_class;
    logic [2:0]        road_class;
    logic [7:0]        road_end_row;
    logic signed [7:0] line_offset;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] drive;
    reason_t            drive_reason;
  } out_word_t;

  typedef struct packed {
    reg_idx_t    index;
    logic [15:0] value;
  } cfg_word_t;

  typedef struct packed {
    logic [6:0] kp;
    logic [1:0] ki;
    logic [1:0] kd;
  } coef_t;

  typedef struct packed {
    logic signed [9:0] tgt;
    coef_t             coef;
  } gains_t;

  typedef struct packed {
    logic [15:0] encoder_count;
    logic        moving_forward;
    logic        start_line_seen;
    gains_t      gains;
  } sched_word_t;

  // speed error width: holds target minus a full-range signed speed
  function automatic int err_bits(input int count_bits);
    return (count_bits + 2 > 11) ? count_bits + 2 : 11;
  endfunction

  typedef logic [8:0] sq_tab_t [129];

  function automatic sq_tab_t sq_div35_tab();
    sq_tab_t t;
    for (int i = 0; i <= 128; i++) t[i] = 9'((i * i) / 35);
    return t;
  endfunction

  function automatic sq_tab_t sq_div40_tab();
    sq_tab_t t;
    for (int i = 0; i <= 128; i++) t[i] = 9'((i * i) / 40);
    return t;
  endfunction

  // offset squared over 35 and over 40, indexed by the offset magnitude
  localparam sq_tab_t SQ_DIV35 = sq_div35_tab();
  localparam sq_tab_t SQ_DIV40 = sq_div40_tab();

endpackage

### hdl/mspid_chan.sv
interface mspid_chan #(parameter type data_t = logic);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hdl/motor_speed_pid_scheduled_top.sv
// gain-scheduled pid speed controller for the drive motor, one word per control tick
// pipeline: input, schedule, tracking, product, magnitude, quotient and output registers
// throughput: one sample word per cycle while result words are taken; the loop state closes within the single
//   tracking stage, so back-to-back words see the state left by the one before
// reset (rst, synchronous): pipeline emptied, loop state zeroed, mode 0, drive limits +-1000
module motor_speed_pid_scheduled_top #(
  parameter int COUNT_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  mspid_chan.sink    sample,
  mspid_chan.source  result,
  mspid_chan.sink    cfg
);
  import mspid_pkg::*;

  // COUNT_BITS is the encoder counter width used for wraparound, 8 to 32
  localparam int EW = err_bits(COUNT_BITS);

  // configuration registers
  mode_t              drive_mode;
  logic signed [15:0] drive_max;
  logic signed [15:0] drive_min;

  // schedule stage to tracking stage
  logic        sched_valid;
  logic        sched_ready;
  sched_word_t sched_word;

  // tracking stage to pid arithmetic
  logic                 pid_valid;
  logic                 pid_ready;
  reason_t              pid_reason;
  coef_t                pid_coef;
  logic signed [EW-1:0] pid_err;
  logic signed [12:0]   pid_sum;
  logic signed [EW:0]   pid_diff;

  // configuration writes are always taken; index three is ignored
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      drive_mode <= MODE_RACE;
      drive_max  <= 16'sd1000;
      drive_min  <= -16'sd1000;
    end else if (cfg.valid) begin
      unique case (cfg.data.index)
        REG_DRIVE_MODE: drive_mode <= mode_t'(cfg.data.value[1:0]);
        REG_DRIVE_MAX:  drive_max  <= $signed(cfg.data.value);
        REG_DRIVE_MIN:  drive_min  <= $signed(cfg.data.value);
        default: ;
      endcase
    end
  end

  // input register and target/gain schedule lookup
  mspid_sched u_sched (
    .clk         (clk),
    .rst         (rst),
    .drive_mode  (drive_mode),
    .sample      (sample),
    .sched_valid (sched_valid),
    .sched_ready (sched_ready),
    .sched_word  (sched_word)
  );

  // speed, warm-up, stall, start-line sequence and integral update
  mspid_track #(
    .COUNT_BITS (COUNT_BITS)
  ) u_track (
    .clk         (clk),
    .rst         (rst),
    .drive_mode  (drive_mode),
    .sched_valid (sched_valid),
    .sched_ready (sched_ready),
    .sched_word  (sched_word),
    .pid_valid   (pid_valid),
    .pid_ready   (pid_ready),
    .pid_reason  (pid_reason),
    .pid_coef    (pid_coef),
    .pid_err     (pid_err),
    .pid_sum     (pid_sum),
    .pid_diff    (pid_diff)
  );

  // products, saturation, divide by ten, drive clamp and output register
  mspid_pid #(
    .COUNT_BITS (COUNT_BITS)
  ) u_pid (
    .clk        (clk),
    .rst        (rst),
    .drive_max  (drive_max),
    .drive_min  (drive_min),
    .pid_valid  (pid_valid),
    .pid_ready  (pid_ready),
    .pid_reason (pid_reason),
    .pid_coef   (pid_coef),
    .pid_err    (pid_err),
    .pid_sum    (pid_sum),
    .pid_diff   (pid_diff),
    .result     (result)
  );

endmodule

### hdl/mspid_sched.sv
module mspid_sched (
  input  logic                  clk,
  input  logic                  rst,
  input  mspid_pkg::mode_t      drive_mode,
  mspid_chan.sink               sample,
  output logic                  sched_valid,
  input  logic                  sched_ready,
  output mspid_pkg::sched_word_t sched_word
);
  import mspid_pkg::*;

  logic     in_valid;
  in_word_t in_word;
  logic     in_free;
  logic     out_free;

  logic [7:0]        abs_off;
  logic [8:0]        q35;
  logic [8:0]        q40;
  logic              fast;
  logic signed [9:0] tgt;
  logic [6:0]        kp;
  logic [1:0]        ki;
  logic [1:0]        kd;
  sched_word_t       sched_word_next;

  assign out_free     = !sched_valid || sched_ready;
  assign in_free      = !in_valid || out_free;
  assign sample.ready = in_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid    <= 1'b0;
      sched_valid <= 1'b0;
    end else begin
      if (in_free) in_valid <= sample.valid;
      if (out_free) sched_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_free && sample.valid) in_word <= sample.data;
    if (out_free && in_valid) sched_word <= sched_word_next;
  end

  always_comb begin
    abs_off = in_word.line_offset[7] ? 8'(-in_word.line_offset) : 8'(in_word.line_offset);
    q35     = SQ_DIV35[abs_off];
    q40     = SQ_DIV40[abs_off];
    fast    = (drive_mode == MODE_RACE) || (drive_mode == MODE_FAST);
    tgt     = 10'sd0;
    kp      = 7'd0;
    ki      = 2'd1;
    kd      = 2'd2;
    priority if (in_word.slope_class == SLOPE_UP1) begin
      tgt = fast ? 10'sd220 : 10'sd180;
      kp  = 7'd65;
    end else if (in_word.slope_class == SLOPE_UP2) begin
      tgt = fast ? 10'sd165 : 10'sd140;
      kp  = 7'd60;
    end else if (fast && in_word.road_class == ROAD_STRAIGHT) begin
      tgt = (drive_mode == MODE_RACE) ? 10'sd280 : 10'sd265;
      kp  = 7'd55;
    end else if (fast && in_word.road_class == ROAD_SMALL_S) begin
      tgt = (drive_mode == MODE_RACE) ? 10'sd240 : 10'sd235;
      kp  = 7'd55;
    end else if (fast && in_word.road_class == ROAD_T_JUNCTION) begin
      tgt = (drive_mode == MODE_RACE) ? 10'sd180 : 10'sd170;
      kp  = 7'd60;
    end else if (fast && in_word.road_class == ROAD_U_TURN) begin
      tgt = (drive_mode == MODE_RACE) ? 10'sd148 : 10'sd145;
      kp  = (drive_mode == MODE_RACE) ? 7'd70 : 7'd55;
    end else if (in_word.road_end_row < 8'd15) begin
      unique case (drive_mode)
        MODE_RACE: begin
          tgt = 10'sd200;
          kp  = 7'd65;
        end
        MODE_FAST: begin
          tgt = 10'sd187;
          kp  = 7'd55;
        end
        MODE_STEADY: begin
          tgt = 10'sd180;
          kp  = 7'd55;
        end
        MODE_SAFE: begin
          tgt = 10'sd175;
          kp  = 7'd55;
        end
      endcase
    end else if (in_word.road_end_row < 8'd30) begin
      ki = 2'd2;
      kp = (drive_mode == MODE_RACE) ? 7'd65 : 7'd55;
      unique case (drive_mode)
        MODE_RACE:   tgt = 10'sd180 - $signed({1'b0, q35});
        MODE_FAST:   tgt = 10'sd172 - $signed({1'b0, q35});
        MODE_STEADY: tgt = 10'sd160 - $signed({1'b0, q35});
        MODE_SAFE:   tgt = 10'sd155 - $signed({1'b0, q40});
      endcase
    end else begin
      ki = 2'd2;
      kd = 2'd3;
      unique case (drive_mode)
        MODE_RACE: begin
          tgt = 10'sd148;
          kp  = 7'd70;
        end
        MODE_FAST: begin
          tgt = 10'sd145;
          kp  = 7'd70;
        end
        MODE_STEADY: begin
          tgt = 10'sd135;
          kp  = 7'd75;
        end
        MODE_SAFE: begin
          tgt = 10'sd130;
          kp  = 7'd55;
          kd  = 2'd2;
        end
      endcase
    end

    sched_word_next.encoder_count   = in_word.encoder_count;
    sched_word_next.moving_forward  = in_word.moving_forward;
    sched_word_next.start_line_seen = in_word.start_line_seen;
    sched_word_next.gains.tgt       = tgt;
    sched_word_next.gains.coef.kp   = kp;
    sched_word_next.gains.coef.ki   = ki;
    sched_word_next.gains.coef.kd   = kd;
  end

endmodule

### hdl/mspid_track.sv
module mspid_track #(
  parameter int COUNT_BITS = 16,
  localparam int EW = mspid_pkg::err_bits(COUNT_BITS)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  mspid_pkg::mode_t       drive_mode,
  input  logic                   sched_valid,
  output logic                   sched_ready,
  input  mspid_pkg::sched_word_t sched_word,
  output logic                   pid_valid,
  input  logic                   pid_ready,
  output mspid_pkg::reason_t     pid_reason,
  output mspid_pkg::coef_t       pid_coef,
  output logic signed [EW-1:0]   pid_err,
  output logic signed [12:0]     pid_sum,
  output logic signed [EW:0]     pid_diff
);
  import mspid_pkg::*;

  // loop state
  logic [COUNT_BITS-1:0] last_count;
  logic [8:0]            tick_timer;
  logic [5:0]            still_ticks;
  logic signed [12:0]    error_sum;
  logic signed [EW-1:0]  prev_error;
  logic [5:0]            line_delay;
  logic [1:0]            stop_stage;

  logic                   fire;
  logic [COUNT_BITS+15:0] count_ext;
  logic [COUNT_BITS-1:0]  count_m;
  logic [COUNT_BITS-1:0]  delta;
  logic [EW-1:0]          spd_mag;
  logic signed [EW-1:0]   speed;
  logic signed [EW-1:0]   tgt_w;
  logic signed [EW-1:0]   err;
  logic signed [EW+1:0]   sum_wide;
  logic signed [12:0]     sum_base;
  logic signed [12:0]     sum_clamp;
  logic signed [EW:0]     diff;
  logic                   warm;
  logic [5:0]             still_next;
  logic [5:0]             ld_inc;
  logic [5:0]             thr;
  logic                   hit;
  logic                   stall;
  logic [8:0]             t_inc;
  logic                   early;
  logic                   emit;
  reason_t                reason;

  assign sched_ready = !pid_valid || pid_ready;
  assign fire        = sched_valid && sched_ready;

  always_comb begin
    count_ext  = {COUNT_BITS'(0), sched_word.encoder_count};
    count_m    = count_ext[COUNT_BITS-1:0];
    delta      = count_m - last_count;
    spd_mag    = EW'({1'b0, delta});
    speed      = sched_word.moving_forward ? $signed(spd_mag) : -$signed(spd_mag);
    warm       = tick_timer < 9'(WARMUP_TICKS);
    still_next = (speed != '0) ? 6'd0 :
                 (still_ticks == 6'(STILL_MAX)) ? still_ticks : still_ticks + 6'd1;
    ld_inc     = line_delay + 6'd1;
    thr        = (drive_mode == MODE_RACE || drive_mode == MODE_FAST) ?
                 6'(THR_FAST) : 6'(THR_SLOW);
    hit        = sched_word.start_line_seen && (ld_inc == thr);
    stall      = still_next > 6'(STALL_LIMIT);

    t_inc    = tick_timer + 9'd1;
    early    = t_inc < 9'(EARLY_END);
    tgt_w    = EW'(sched_word.gains.tgt);
    // overspeed in the early phase drops the integral
    sum_base = (early && speed > tgt_w) ? 13'sd0 : error_sum;
    err      = tgt_w - speed;
    sum_wide = (EW+2)'(sum_base) + (EW+2)'(err);
    priority if (sum_wide > (EW+2)'(SUM_LIMIT)) sum_clamp = 13'(SUM_LIMIT);
    else if (sum_wide < (EW+2)'(-SUM_LIMIT)) sum_clamp = 13'(-SUM_LIMIT);
    else sum_clamp = 13'(sum_wide);
    diff = (EW+1)'(err) - (EW+1)'(prev_error);

    priority if (hit && stop_stage == 2'd2) reason = RSN_STOPPED;
    else if (hit) reason = RSN_BRAKE;
    else if (stall) reason = RSN_STALL;
    else reason = RSN_PID;

    emit = !warm && (!hit || stop_stage == 2'd2 || sched_word.moving_forward);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_count  <= '0;
      tick_timer  <= '0;
      still_ticks <= '0;
      error_sum   <= '0;
      prev_error  <= '0;
      line_delay  <= '0;
      stop_stage  <= '0;
      pid_valid   <= 1'b0;
    end else begin
      if (sched_ready) pid_valid <= fire && emit;
      if (fire) begin
        if (warm) begin
          tick_timer <= t_inc;
        end else begin
          last_count  <= count_m;
          still_ticks <= still_next;
          if (sched_word.start_line_seen) line_delay <= hit ? line_delay : ld_inc;
          if (hit && stop_stage != 2'd2 && !sched_word.moving_forward) begin
            stop_stage <= stop_stage + 2'd1;
          end
          if (!hit && !stall) begin
            if (early) tick_timer <= t_inc;
            error_sum  <= sum_clamp;
            prev_error <= err;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      pid_reason <= reason;
      pid_coef   <= sched_word.gains.coef;
      pid_err    <= err;
      pid_sum    <= sum_clamp;
      pid_diff   <= diff;
    end
  end

endmodule

### hdl/mspid_pid.sv
module mspid_pid #(
  parameter int COUNT_BITS = 16,
  localparam int EW = mspid_pkg::err_bits(COUNT_BITS)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic signed [15:0]   drive_max,
  input  logic signed [15:0]   drive_min,
  input  logic                 pid_valid,
  output logic                 pid_ready,
  input  mspid_pkg::reason_t   pid_reason,
  input  mspid_pkg::coef_t     pid_coef,
  input  logic signed [EW-1:0] pid_err,
  input  logic signed [12:0]   pid_sum,
  input  logic signed [EW:0]   pid_diff,
  mspid_chan.source            result
);
  import mspid_pkg::*;

  localparam int AW = EW + 9;

  // product stage
  logic                 m_valid;
  reason_t              m_reason;
  logic signed [EW+7:0] m_p;
  logic signed [15:0]   m_i;
  logic signed [EW+3:0] m_d;

  // saturated magnitude stage
  logic        a_valid;
  reason_t     a_reason;
  logic [19:0] a_mag;
  logic        a_neg;

  // quotient stage
  logic        q_valid;
  reason_t     q_reason;
  logic [15:0] q_val;
  logic        q_neg;

  logic m_free;
  logic a_free;
  logic q_free;
  logic out_free;

  logic signed [EW+7:0] p_next;
  logic signed [15:0]   i_next;
  logic signed [EW+3:0] d_next;
  logic signed [AW-1:0] acc;
  logic signed [19:0]   acc_sat;
  logic [19:0]          mag_next;
  logic [39:0]          prod;
  logic signed [16:0]   dq;
  logic signed [15:0]   pid_drive;
  out_word_t            out_next;

  assign out_free  = !result.valid || result.ready;
  assign q_free    = !q_valid || out_free;
  assign a_free    = !a_valid || q_free;
  assign m_free    = !m_valid || a_free;
  assign pid_ready = m_free;

  always_comb begin
    p_next = $signed({1'b0, pid_coef.kp}) * pid_err;
    i_next = $signed({1'b0, pid_coef.ki}) * pid_sum;
    d_next = $signed({1'b0, pid_coef.kd}) * pid_diff;

    acc = AW'(m_p) + AW'(m_i) + AW'(m_d);
    // clip far outside the drive range so the divide stays narrow
    priority if (acc > AW'(SAT_MAX)) acc_sat = 20'(SAT_MAX);
    else if (acc < AW'(SAT_MIN)) acc_sat = 20'(SAT_MIN);
    else acc_sat = 20'(acc);
    mag_next = acc_sat[19] ? 20'(-acc_sat) : 20'(acc_sat);

    prod = a_mag * 21'(RECIP_10);

    // divide truncates toward zero, then the max clamp wins over the min clamp
    dq = q_neg ? -$signed({1'b0, q_val}) : $signed({1'b0, q_val});
    priority if (dq > 17'(drive_max)) pid_drive = drive_max;
    else if (dq < 17'(drive_min)) pid_drive = drive_min;
    else pid_drive = dq[15:0];

    out_next.drive_reason = q_reason;
    unique case (q_reason)
      RSN_PID:     out_next.drive = pid_drive;
      RSN_BRAKE:   out_next.drive = 16'(BRAKE_DRIVE);
      RSN_STOPPED: out_next.drive = 16'sd0;
      RSN_STALL:   out_next.drive = 16'sd0;
      default:     out_next.drive = 16'sd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid      <= 1'b0;
      a_valid      <= 1'b0;
      q_valid      <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      if (m_free) m_valid <= pid_valid;
      if (a_free) a_valid <= m_valid;
      if (q_free) q_valid <= a_valid;
      if (out_free) result.valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (m_free && pid_valid) begin
      m_reason <= pid_reason;
      m_p      <= p_next;
      m_i      <= i_next;
      m_d      <= d_next;
    end
    if (a_free && m_valid) begin
      a_reason <= m_reason;
      a_mag    <= mag_next;
      a_neg    <= acc_sat[19];
    end
    if (q_free && a_valid) begin
      q_reason <= a_reason;
      q_val    <= prod[RECIP_SHIFT+15:RECIP_SHIFT];
      q_neg    <= a_neg;
    end
    if (out_free && q_valid) result.data <= out_next;
  end

endmodule

### hdl/mspid_checker.sv
module mspid_checker (
  input logic               clk,
  input logic               rst,
  input logic               result_valid,
  input logic               result_ready,
  input logic signed [15:0] result_drive,
  input logic [1:0]         result_reason
);
  import mspid_pkg::*;

  a_rst_clears: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result word valid right after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid)
    else $error("result word dropped while stalled");

  a_hold_word: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> $stable(result_drive) && $stable(result_reason))
    else $error("result word changed while stalled");

  a_brake_drive: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_reason == RSN_BRAKE |-> result_drive == -16'sd300)
    else $error("brake word without brake drive");

  a_zero_drive: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result_reason == RSN_STOPPED || result_reason == RSN_STALL)
    |-> result_drive == 16'sd0)
    else $error("stop or stall word with nonzero drive");

endmodule

bind motor_speed_pid_scheduled_top mspid_checker u_mspid_checker (
  .clk           (clk),
  .rst           (rst),
  .result_valid  (result.valid),
  .result_ready  (result.ready),
  .result_drive  (result.data.drive),
  .result_reason (result.data.drive_reason)
);
